// ===== rtl/ptdc_pkg.sv =====
`timescale 1ns / 1ps

package ptdc_pkg;

  localparam int KindW = 3;
  localparam int VolW = 24;
  localparam int DvdW = 34;
  localparam int FlowW = 16;
  localparam int CntW = 6;

  localparam logic [KindW-1:0] KIND_TICK = 3'd0;
  localparam logic [KindW-1:0] KIND_ON = 3'd1;
  localparam logic [KindW-1:0] KIND_OFF = 3'd2;
  localparam logic [KindW-1:0] KIND_TIMED = 3'd3;
  localparam logic [KindW-1:0] KIND_STOP = 3'd4;
  localparam logic [KindW-1:0] KIND_DRIP = 3'd5;
  localparam logic [KindW-1:0] KIND_DISPENSE = 3'd6;
  localparam logic [KindW-1:0] KIND_CLEAR = 3'd7;

  localparam logic [1:0] REG_ACTIVE_HIGH = 2'd0;
  localparam logic [1:0] REG_FLOW_RATE = 2'd1;
  localparam logic [1:0] REG_DRIP_ON = 2'd2;
  localparam logic [1:0] REG_DRIP_OFF = 2'd3;

  typedef struct packed {
    logic apply;       // apply the accepted request directly
    logic div_start;   // load the divider for a dispense
    logic div_commit;  // apply the finished dispense as a timed run
    logic load_out;    // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic needs_div;   // request at the input is a dispense with nonzero flow
    logic div_done;
  } status_t;

endpackage

// ===== rtl/ptdc_ctrl.sv =====
`timescale 1ns / 1ps

module ptdc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ptdc_pkg::status_t sts,
  output ptdc_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_take;
  logic       accept;

  // output register is free now or is emptied at this edge
  assign can_take = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && can_take);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.needs_div) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end else begin
            cmd.apply = 1'b1;
            cmd.load_out = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (can_take) begin
          cmd.div_commit = 1'b1;
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while a dispense is in progress");

  a_start_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == S_DIV))
    else $error("divider started without entering divide state");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.load_out)
    else $error("stalled result overwritten");

endmodule

// ===== rtl/ptdc_datapath.sv =====
`timescale 1ns / 1ps

module ptdc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ptdc_pkg::cmd_t               cmd,
  output ptdc_pkg::status_t            sts,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [ptdc_pkg::KindW-1:0]   kind,
  input  logic [31:0]                  duration_ms,
  input  logic [31:0]                  drops_wanted,
  input  logic [ptdc_pkg::VolW-1:0]    volume,
  output logic                         pump_on,
  output logic                         drive_level,
  output logic                         changed,
  output logic                         dripping,
  output logic [31:0]                  total_drops,
  output logic                         rejected
);

  // configuration
  logic                       active_high;
  logic [ptdc_pkg::FlowW-1:0] flow_rate;
  logic [31:0]                drip_on_ms;
  logic [31:0]                drip_off_ms;

  // controller state
  logic [31:0] clock_ms;
  logic        running;
  logic        timer_armed;
  logic [31:0] timer_deadline;
  logic        drip_active;
  logic        drip_phase_on;
  logic [31:0] phase_deadline;
  logic [31:0] drops_this_run;
  logic [31:0] drops_target;
  logic [31:0] drop_total;
  logic        last_reported;

  // divider
  logic [ptdc_pkg::DvdW-1:0]  dvd;
  logic [ptdc_pkg::FlowW-1:0] rem;
  logic [ptdc_pkg::CntW-1:0]  div_cnt;
  logic [ptdc_pkg::FlowW:0]   trial;
  logic                       fits;
  logic [ptdc_pkg::DvdW-1:0]  scaled;
  logic [31:0]                ms_sat;

  // next values
  logic [ptdc_pkg::KindW-1:0] eff_kind;
  logic [31:0] eff_dur;
  logic [31:0] clock_ms_next;
  logic        running_next;
  logic        timer_armed_next;
  logic [31:0] timer_deadline_next;
  logic        drip_active_next;
  logic        drip_phase_on_next;
  logic [31:0] phase_deadline_next;
  logic [31:0] drops_this_run_next;
  logic [31:0] drops_target_next;
  logic [31:0] drop_total_next;
  logic        rejected_next;

  // volume * 1000 = v*1024 - v*16 - v*8
  assign scaled = ({{(ptdc_pkg::DvdW-ptdc_pkg::VolW){1'b0}}, volume} << 10)
                - ({{(ptdc_pkg::DvdW-ptdc_pkg::VolW){1'b0}}, volume} << 4)
                - ({{(ptdc_pkg::DvdW-ptdc_pkg::VolW){1'b0}}, volume} << 3);

  assign trial = {rem, dvd[ptdc_pkg::DvdW-1]};
  assign fits = (trial >= {1'b0, flow_rate});
  assign ms_sat = (|dvd[ptdc_pkg::DvdW-1:32]) ? 32'hFFFF_FFFF : dvd[31:0];

  assign sts.needs_div = (kind == ptdc_pkg::KIND_DISPENSE) && (flow_rate != '0);
  assign sts.div_done = (div_cnt == '0);

  always_comb begin
    eff_kind = cmd.div_commit ? ptdc_pkg::KIND_TIMED : kind;
    eff_dur = cmd.div_commit ? ms_sat : duration_ms;
    clock_ms_next = clock_ms;
    running_next = running;
    timer_armed_next = timer_armed;
    timer_deadline_next = timer_deadline;
    drip_active_next = drip_active;
    drip_phase_on_next = drip_phase_on;
    phase_deadline_next = phase_deadline;
    drops_this_run_next = drops_this_run;
    drops_target_next = drops_target;
    drop_total_next = drop_total;
    rejected_next = 1'b0;
    case (eff_kind)
      ptdc_pkg::KIND_TICK: begin
        clock_ms_next = clock_ms + 32'd1;
        if (timer_armed && (clock_ms_next >= timer_deadline)) begin
          running_next = 1'b0;
          timer_armed_next = 1'b0;
        end
        if (drip_active && (clock_ms_next >= phase_deadline)) begin
          if (drip_phase_on) begin
            running_next = 1'b0;
            timer_armed_next = 1'b0;
            drip_phase_on_next = 1'b0;
            phase_deadline_next = clock_ms_next + drip_off_ms;
          end else if (drops_this_run < drops_target) begin
            running_next = 1'b1;
            timer_armed_next = 1'b0;
            drops_this_run_next = drops_this_run + 32'd1;
            drop_total_next = drop_total + 32'd1;
            drip_phase_on_next = 1'b1;
            phase_deadline_next = clock_ms_next + drip_on_ms;
          end else begin
            drip_active_next = 1'b0;
          end
        end
      end
      ptdc_pkg::KIND_ON: begin
        running_next = 1'b1;
        timer_armed_next = 1'b0;
      end
      ptdc_pkg::KIND_OFF: begin
        running_next = 1'b0;
        timer_armed_next = 1'b0;
      end
      ptdc_pkg::KIND_TIMED: begin
        running_next = 1'b1;
        timer_armed_next = 1'b1;
        timer_deadline_next = clock_ms + eff_dur;
      end
      ptdc_pkg::KIND_STOP: begin
        drip_active_next = 1'b0;
        running_next = 1'b0;
        timer_armed_next = 1'b0;
      end
      ptdc_pkg::KIND_DRIP: begin
        drops_target_next = drops_wanted;
        drip_active_next = 1'b1;
        drip_phase_on_next = 1'b1;
        phase_deadline_next = clock_ms + drip_on_ms;
        drops_this_run_next = 32'd1;
        drop_total_next = 32'd1;
        running_next = 1'b1;
        timer_armed_next = 1'b0;
      end
      // only reaches here directly when flow is zero
      ptdc_pkg::KIND_DISPENSE: rejected_next = 1'b1;
      ptdc_pkg::KIND_CLEAR: drop_total_next = 32'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high <= 1'b1;
      flow_rate <= '0;
      drip_on_ms <= '0;
      drip_off_ms <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptdc_pkg::REG_ACTIVE_HIGH: active_high <= cfg_data[0];
        ptdc_pkg::REG_FLOW_RATE: flow_rate <= cfg_data[ptdc_pkg::FlowW-1:0];
        ptdc_pkg::REG_DRIP_ON: drip_on_ms <= cfg_data;
        ptdc_pkg::REG_DRIP_OFF: drip_off_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms <= '0;
      running <= 1'b0;
      timer_armed <= 1'b0;
      timer_deadline <= '0;
      drip_active <= 1'b0;
      drip_phase_on <= 1'b0;
      phase_deadline <= '0;
      drops_this_run <= '0;
      drops_target <= '0;
      drop_total <= '0;
      last_reported <= 1'b0;
    end else if (cmd.apply || cmd.div_commit) begin
      clock_ms <= clock_ms_next;
      running <= running_next;
      timer_armed <= timer_armed_next;
      timer_deadline <= timer_deadline_next;
      drip_active <= drip_active_next;
      drip_phase_on <= drip_phase_on_next;
      phase_deadline <= phase_deadline_next;
      drops_this_run <= drops_this_run_next;
      drops_target <= drops_target_next;
      drop_total <= drop_total_next;
      last_reported <= running_next;
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts into dvd
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= ptdc_pkg::CntW'(ptdc_pkg::DvdW);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= scaled;
      rem <= '0;
    end else if (div_cnt != '0) begin
      rem <= fits ? ptdc_pkg::FlowW'(trial - {1'b0, flow_rate})
                  : trial[ptdc_pkg::FlowW-1:0];
      dvd <= {dvd[ptdc_pkg::DvdW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pump_on <= running_next;
      drive_level <= ~(running_next ^ active_high);
      changed <= running_next ^ last_reported;
      dripping <= drip_active_next;
      total_drops <= drop_total_next;
      rejected <= rejected_next;
    end
  end

endmodule

// ===== rtl/pump_timed_drip_controller_core.sv =====
`timescale 1ns / 1ps

// Pump timed drip controller.
// Input channel (in_valid / in_stall) carries one request: a 1 ms tick or a
// pump command selected by kind. Each accepted request yields exactly one
// result on the output channel (out_valid / out_stall) with pump state, pin
// level, change flag, drip status, drop total and the dispense reject flag.
// Any request but an accepted dispense with a nonzero flow rate is applied
// and its result registered as it is taken. Such a dispense runs the
// restoring divider for volume*1000/flow, one of 34 quotient bits per
// cycle, then commits the quotient as a timed run when the output register
// can take it. One request is in work at a time: others are taken every
// cycle it can take them, and a dispense holds the input until committed.
// The result sits in an output register; the next request is taken while
// it waits, as long as it is being taken at the same edge or the register
// is empty. If the receiver stalls with a result pending, in_stall rises
// and the pending result holds.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used only while the block is idle.
// Synchronous reset (rst) clears the pump state, the clock, the drip run and
// the drop total and loads the default registers (active high, flow zero).
module pump_timed_drip_controller_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ptdc_pkg::KindW-1:0] kind,
  input  logic [31:0]                duration_ms,
  input  logic [31:0]                drops_wanted,
  input  logic [ptdc_pkg::VolW-1:0]  volume,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       pump_on,
  output logic                       drive_level,
  output logic                       changed,
  output logic                       dripping,
  output logic [31:0]                total_drops,
  output logic                       rejected
);

  ptdc_pkg::cmd_t    cmd;
  ptdc_pkg::status_t sts;

  ptdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptdc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .duration_ms  (duration_ms),
    .drops_wanted (drops_wanted),
    .volume       (volume),
    .pump_on      (pump_on),
    .drive_level  (drive_level),
    .changed      (changed),
    .dripping     (dripping),
    .total_drops  (total_drops),
    .rejected     (rejected)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_REQUESTS = 100;

  typedef struct packed {
    logic        pump_on;
    logic        drive_level;
    logic        changed;
    logic        dripping;
    logic [31:0] total_drops;
    logic        rejected;
  } pump_result_t;

  // Tracks pump, timer and drip state and holds the results still owed.
  class pump_tracker;
    bit          high_level = 1'b1;
    bit [15:0]   flow_cfg;
    bit [31:0]   drip_on_cfg;
    bit [31:0]   drip_off_cfg;

    bit [31:0]   clock_ms;
    bit          running;
    bit          timer_armed;
    bit [31:0]   timer_deadline;
    bit          drip_active;
    bit          phase_on;
    bit [31:0]   phase_deadline;
    bit [31:0]   drops_run;
    bit [31:0]   drops_target;
    bit [31:0]   drop_total;
    bit          last_pump;

    pump_result_t expected_results[$];
    int          mismatches;

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        ptdc_pkg::REG_ACTIVE_HIGH: high_level = data[0];
        ptdc_pkg::REG_FLOW_RATE: flow_cfg = data[15:0];
        ptdc_pkg::REG_DRIP_ON: drip_on_cfg = data;
        default: drip_off_cfg = data;
      endcase
    endfunction

    function void set_pump(bit on);
      running = on;
      timer_armed = 1'b0;
    endfunction

    function void start_timed(bit [31:0] dur);
      set_pump(1'b1);
      timer_deadline = clock_ms + dur;
      timer_armed = 1'b1;
    endfunction

    // Timer first, then the drip phase; unsigned compares, no wrap handling.
    function void advance_ms();
      clock_ms = clock_ms + 32'd1;
      if (timer_armed && clock_ms >= timer_deadline) set_pump(1'b0);
      if (drip_active && clock_ms >= phase_deadline) begin
        if (phase_on) begin
          set_pump(1'b0);
          phase_on = 1'b0;
          phase_deadline = clock_ms + drip_off_cfg;
        end else if (drops_run < drops_target) begin
          set_pump(1'b1);
          drops_run = drops_run + 32'd1;
          drop_total = drop_total + 32'd1;
          phase_on = 1'b1;
          phase_deadline = clock_ms + drip_on_cfg;
        end else begin
          drip_active = 1'b0;
        end
      end
    endfunction

    function void note_request(logic [2:0] kind_in, logic [31:0] dur, logic [31:0] wanted,
                               logic [23:0] vol);
      pump_result_t r;
      bit [63:0] ms;
      r = '0;
      case (kind_in)
        ptdc_pkg::KIND_TICK: advance_ms();
        ptdc_pkg::KIND_ON: set_pump(1'b1);
        ptdc_pkg::KIND_OFF: set_pump(1'b0);
        ptdc_pkg::KIND_TIMED: start_timed(dur);
        ptdc_pkg::KIND_STOP: begin
          drip_active = 1'b0;
          set_pump(1'b0);
        end
        ptdc_pkg::KIND_DRIP: begin
          drops_target = wanted;
          drip_active = 1'b1;
          phase_on = 1'b1;
          phase_deadline = clock_ms + drip_on_cfg;
          drops_run = 32'd1;
          drop_total = 32'd1;
          set_pump(1'b1);
        end
        ptdc_pkg::KIND_DISPENSE: begin
          if (flow_cfg == 16'd0) begin
            r.rejected = 1'b1;
          end else begin
            ms = (64'(vol) * 64'd1000) / 64'(flow_cfg);
            if (ms > 64'hFFFF_FFFF) ms = 64'hFFFF_FFFF;
            start_timed(ms[31:0]);
          end
        end
        default: drop_total = 32'd0;
      endcase
      r.pump_on = running;
      r.drive_level = high_level ? running : !running;
      r.changed = (running != last_pump);
      last_pump = running;
      r.dripping = drip_active;
      r.total_drops = drop_total;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(pump_result_t got);
      pump_result_t want;
      if (expected_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.pump_on !== want.pump_on)
        report($sformatf("pump_on got %b want %b", got.pump_on, want.pump_on));
      if (got.drive_level !== want.drive_level)
        report($sformatf("drive_level got %b want %b", got.drive_level, want.drive_level));
      if (got.changed !== want.changed)
        report($sformatf("changed got %b want %b", got.changed, want.changed));
      if (got.dripping !== want.dripping)
        report($sformatf("dripping got %b want %b", got.dripping, want.dripping));
      if (got.total_drops !== want.total_drops)
        report($sformatf("total_drops got %h want %h", got.total_drops, want.total_drops));
      if (got.rejected !== want.rejected)
        report($sformatf("rejected got %b want %b", got.rejected, want.rejected));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_index = ptdc_pkg::REG_ACTIVE_HIGH;
  logic [31:0]                 cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ptdc_pkg::KindW-1:0]  kind = ptdc_pkg::KIND_TICK;
  logic [31:0]                 duration_ms = '0;
  logic [31:0]                 drops_wanted = '0;
  logic [ptdc_pkg::VolW-1:0]   volume = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        pump_on;
  logic                        drive_level;
  logic                        changed;
  logic                        dripping;
  logic [31:0]                 total_drops;
  logic                        rejected;

  pump_tracker sb = new;
  int idle_pct = 25;
  int cycle_count = 0;

  pump_timed_drip_controller_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .duration_ms(duration_ms),
    .drops_wanted(drops_wanted),
    .volume(volume),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pump_on(pump_on),
    .drive_level(drive_level),
    .changed(changed),
    .dripping(dripping),
    .total_drops(total_drops),
    .rejected(rejected)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(logic [2:0] k, logic [31:0] dur, logic [31:0] wanted,
                              logic [23:0] vol);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    duration_ms <= dur;
    drops_wanted <= wanted;
    volume <= vol;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, dur, wanted, vol);
  endtask

  task automatic configure(logic high, logic [15:0] flow, logic [31:0] on_ms,
                           logic [31:0] off_ms);
    logic [31:0] vals [4];
    vals[0] = {31'd0, high};
    vals[1] = {16'd0, flow};
    vals[2] = on_ms;
    vals[3] = off_ms;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_request();
    logic [2:0] k;
    logic [31:0] d;
    logic [31:0] w;
    logic [23:0] v;
    int r;
    d = $urandom();
    w = $urandom();
    v = 24'($urandom());
    r = $urandom_range(99);
    if (r < 65) k = ptdc_pkg::KIND_TICK;
    else if (r < 70) k = ptdc_pkg::KIND_ON;
    else if (r < 74) k = ptdc_pkg::KIND_OFF;
    else if (r < 80) k = ptdc_pkg::KIND_TIMED;
    else if (r < 84) k = ptdc_pkg::KIND_STOP;
    else if (r < 92) k = ptdc_pkg::KIND_DRIP;
    else if (r < 97) k = ptdc_pkg::KIND_DISPENSE;
    else k = ptdc_pkg::KIND_CLEAR;
    // keep runs short enough for ticks to reach the timer and the drip phases
    if (k == ptdc_pkg::KIND_TIMED && $urandom_range(9) != 0) d = $urandom_range(0, 25);
    if (k == ptdc_pkg::KIND_DRIP && $urandom_range(9) != 0) w = $urandom_range(0, 4);
    if (k == ptdc_pkg::KIND_DISPENSE && $urandom_range(7) != 0)
      v = 24'($urandom_range(0, 3000));
    send_request(k, d, w, v);
  endtask

  // Result side: check accepted results, stall at random.
  initial begin : result_side
    pump_result_t got;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.pump_on = pump_on;
        got.drive_level = drive_level;
        got.changed = changed;
        got.dripping = dripping;
        got.total_drops = total_drops;
        got.rejected = rejected;
        sb.check_result(got);
      end
      if (hold == 0) hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    configure(1'b1, 16'd0, 32'd0, 32'd0);

    // zero flow rejects a dispense
    send_request(ptdc_pkg::KIND_DISPENSE, 32'd0, 32'd0, 24'hFF_FFFF);
    send_request(ptdc_pkg::KIND_ON, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_OFF, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_CLEAR, 32'd0, 32'd0, 24'd0);
    wait_idle();
    configure(1'b1, 16'd1, 32'd1, 32'd1);
    // huge dispense saturates the duration
    send_request(ptdc_pkg::KIND_DISPENSE, 32'd0, 32'd0, 24'hFF_FFFF);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_DISPENSE, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    // deadline wraps below the clock and expires at once
    send_request(ptdc_pkg::KIND_TIMED, 32'hFFFF_FFFF, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TIMED, 32'd2, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    // zero drops still gives one
    send_request(ptdc_pkg::KIND_DRIP, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_DRIP, 32'd0, 32'hFFFF_FFFF, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_TICK, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_STOP, 32'd0, 32'd0, 24'd0);
    send_request(ptdc_pkg::KIND_CLEAR, 32'd0, 32'd0, 24'd0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin
          configure(1'b0, 16'hFFFF, 32'd3, 32'd2);
          idle_pct = 30;
        end
        1: begin
          configure(1'b1, 16'd256, 32'd1, 32'd1);
          idle_pct = 0;
        end
        2: begin
          configure(1'b0, 16'd0, 32'd5, 32'd4);
          idle_pct = 50;
        end
        3: begin
          configure(1'b1, 16'd1, 32'd0, 32'd0);
          idle_pct = 20;
        end
        4: begin
          configure(1'b1, 16'($urandom_range(1, 65535)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          idle_pct = 40;
        end
        5: begin
          configure(1'b0, 16'd12000, 32'd7, 32'd0);
          idle_pct = 0;
        end
        default: begin
          configure(1'($urandom_range(1)), 16'($urandom_range(1, 65535)),
                    $urandom_range(0, 9), $urandom_range(0, 9));
          idle_pct = 35;
        end
      endcase
      repeat (PHASE_REQUESTS) random_request();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptdc_pkg.sv
rtl/ptdc_ctrl.sv
rtl/ptdc_datapath.sv
rtl/pump_timed_drip_controller_core.sv
verif/testbench.sv
